FILE: rtl/core/mvna_pkg.sv
// Shared types, constants and state encodings of the vertex normal accumulator.
package mvna_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int IDX_W  = 10;
    localparam int POS_W  = 24;
    localparam int SUM_W  = 32;
    localparam int NRM_W  = 16;
    localparam int CFG_W  = 11;
    localparam int EDGE_W = 25;
    localparam int UNIT_W = 18;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_TRI  = 2'd1,
        MODE_QUAD = 2'd2,
        MODE_READ = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]              mode;
        logic [IDX_W-1:0]        corner_a;
        logic [IDX_W-1:0]        corner_b;
        logic [IDX_W-1:0]        corner_c;
        logic [IDX_W-1:0]        corner_d;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_in;

    typedef struct packed {
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic                    zero_length;
        logic                    bad_index;
    } t_out;

    typedef struct packed {
        logic start;
        logic face;
    } t_vec_ctl;

    typedef struct packed {
        logic done;
        logic zero;
    } t_vec_sts;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_LOAD, S_RDPOS, S_EDGE, S_RDSUM,
        S_VSTART, S_VWAIT, S_ACC_RD, S_ACC_WR, S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        V_IDLE, V_CROSS, V_ABS, V_SHIFT, V_SQ, V_SQRT, V_DSET, V_DIV, V_DONE
    } t_vstate;

endpackage

FILE: rtl/core/mvna_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mvna_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/mvna_vec_unit.sv
// Cross product and unit-length scaling on one shared multiplier.
module mvna_vec_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mvna_pkg::t_vec_ctl                i_ctl,
    input  logic signed [mvna_pkg::EDGE_W-1:0] i_e1 [3],
    input  logic signed [mvna_pkg::EDGE_W-1:0] i_e2 [3],
    input  logic signed [mvna_pkg::SUM_W-1:0]  i_sum [3],
    output mvna_pkg::t_vec_sts                o_sts,
    output logic signed [mvna_pkg::UNIT_W-1:0] o_u [3]
);
    import mvna_pkg::*;

    localparam int CW   = 52;
    localparam int MW   = CW - 1;
    localparam int MULW = 31;
    localparam int PW   = 62;
    localparam int DW   = 47;
    localparam int LW   = 32;
    localparam int QW   = UNIT_W - 1;

    t_vstate r_state, n_state;
    logic [5:0]              r_cnt;
    logic [1:0]              r_k;
    logic signed [CW-1:0]    r_vec [3];
    logic [MW-1:0]           r_mag [3];
    logic                    r_neg [3];
    logic [PW-1:0]           r_sum, r_root, r_bit;
    logic [DW-1:0]           r_num;
    logic [LW-1:0]           r_rem;
    logic [QW-1:0]           r_q;
    logic                    r_face, r_zero;
    logic signed [UNIT_W-1:0] r_u [3];
    logic signed [PW-1:0]    r_prod;

    logic signed [MULW-1:0]  mul_a, mul_b;
    logic [1:0]              acc_j;
    logic                    all_zero, big;
    logic [PW:0]             sq_t;
    logic                    sq_ge;
    logic [LW-1:0]           len;
    logic [DW-1:0]           num;
    logic [LW:0]             rem2;
    logic                    div_ge;
    logic [QW-1:0]           q_fin;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == V_CROSS) begin
            unique case (r_cnt[2:0])
                3'd0: begin mul_a = MULW'(i_e1[1]); mul_b = MULW'(i_e2[2]); end
                3'd1: begin mul_a = MULW'(i_e1[2]); mul_b = MULW'(i_e2[1]); end
                3'd2: begin mul_a = MULW'(i_e1[2]); mul_b = MULW'(i_e2[0]); end
                3'd3: begin mul_a = MULW'(i_e1[0]); mul_b = MULW'(i_e2[2]); end
                3'd4: begin mul_a = MULW'(i_e1[0]); mul_b = MULW'(i_e2[1]); end
                3'd5: begin mul_a = MULW'(i_e1[1]); mul_b = MULW'(i_e2[0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (r_state == V_SQ && r_cnt < 6'd3) begin
            mul_a = signed'({1'b0, r_mag[r_cnt[1:0]][29:0]});
            mul_b = signed'({1'b0, r_mag[r_cnt[1:0]][29:0]});
        end
    end

    always_comb begin
        acc_j    = 2'((r_cnt - 6'd1) >> 1);
        all_zero = (r_vec[0] == '0) && (r_vec[1] == '0) && (r_vec[2] == '0);
        big      = (|r_mag[0][MW-1:30]) | (|r_mag[1][MW-1:30]) | (|r_mag[2][MW-1:30]);
        sq_t     = {1'b0, r_root} + {1'b0, r_bit};
        sq_ge    = {1'b0, r_sum} >= sq_t;
        len      = r_root[LW-1:0];
        num      = (r_face ? DW'({r_mag[r_k][29:0], 16'b0})
                           : DW'({r_mag[r_k][29:0], 14'b0})) + DW'(len >> 1);
        rem2     = {r_rem, r_num[DW-1]};
        div_ge   = rem2 >= {1'b0, len};
        q_fin    = {r_q[QW-2:0], div_ge};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            V_IDLE:  if (i_ctl.start) n_state = i_ctl.face ? V_CROSS : V_ABS;
            V_CROSS: if (r_cnt == 6'd6) n_state = V_ABS;
            V_ABS:   n_state = all_zero ? V_DONE : V_SHIFT;
            V_SHIFT: if (!big) n_state = V_SQ;
            V_SQ:    if (r_cnt == 6'd3) n_state = V_SQRT;
            V_SQRT:  if (r_bit[0]) n_state = V_DSET;
            V_DSET:  n_state = V_DIV;
            V_DIV: begin
                if (r_cnt == 6'(DW - 1)) n_state = (r_k == 2'd2) ? V_DONE : V_DSET;
            end
            V_DONE:  n_state = V_IDLE;
            default: n_state = V_IDLE;
        endcase
    end

    always_comb begin
        o_sts.done = r_state == V_DONE;
        o_sts.zero = r_zero;
        o_u        = r_u;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state <= V_IDLE;
            r_cnt   <= '0;
            r_k     <= '0;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                V_IDLE: begin
                    r_cnt <= '0;
                    if (i_ctl.start) begin
                        r_face <= i_ctl.face;
                        r_zero <= 1'b0;
                        for (int j = 0; j < 3; j++) begin
                            r_vec[j] <= i_ctl.face ? '0 : CW'(i_sum[j]);
                        end
                    end
                end
                V_CROSS: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt != 6'd0) begin
                        if (r_cnt[0]) r_vec[acc_j] <= r_vec[acc_j] + CW'(r_prod);
                        else          r_vec[acc_j] <= r_vec[acc_j] - CW'(r_prod);
                    end
                end
                V_ABS: begin
                    r_zero <= all_zero;
                    for (int j = 0; j < 3; j++) begin
                        r_neg[j] <= r_vec[j][CW-1];
                        r_mag[j] <= MW'(r_vec[j][CW-1] ? -r_vec[j] : r_vec[j]);
                    end
                end
                V_SHIFT: begin
                    r_cnt  <= '0;
                    r_sum  <= '0;
                    r_root <= '0;
                    r_bit  <= PW'(1) << 60;
                    if (big) begin
                        for (int j = 0; j < 3; j++) r_mag[j] <= r_mag[j] >> 1;
                    end
                end
                V_SQ: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt != 6'd0) r_sum <= r_sum + PW'(r_prod);
                    r_k <= '0;
                end
                V_SQRT: begin
                    if (sq_ge) begin
                        r_sum  <= r_sum - PW'(sq_t);
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                V_DSET: begin
                    r_num <= num;
                    r_rem <= '0;
                    r_q   <= '0;
                    r_cnt <= '0;
                end
                V_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    r_num <= r_num << 1;
                    r_rem <= div_ge ? LW'(rem2 - {1'b0, len}) : LW'(rem2);
                    r_q   <= q_fin;
                    if (r_cnt == 6'(DW - 1)) begin
                        r_u[r_k] <= r_neg[r_k] ? -signed'({1'b0, q_fin})
                                               : signed'({1'b0, q_fin});
                        r_k <= r_k + 2'd1;
                    end
                end
                V_DONE: r_cnt <= '0;
                default: r_cnt <= '0;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> r_state == V_IDLE) else $error("start while busy");
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == V_DIV |-> len != '0) else $error("zero divisor");
    a_mag_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == V_SQ |-> !big) else $error("magnitude not reduced");
`endif
endmodule

FILE: rtl/core/mesh_vertex_normal_accumulator_unit.sv
// Top level of the mesh vertex normal accumulator with stores and sequencer.
//
//  channel | direction | handshake          | payload
//  in      | input     | i_in_valid/o_in_stall   | i_in_data (t_in)
//  out     | output    | o_out_valid/i_out_stall | o_out_data (t_out)
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (vertices_in_use)
//
// A read or a face runs through the shared multiplier, the bit-serial square root
// and three bit-serial divisions, and a face adds one read-modify-write pair per
// corner; a zero-length read or a degenerate face skips the root, divisions and writes.
// After reset the normal sum store is cleared entry by entry before input is accepted.
// A result waits in the output register while the stall input is high.
module mesh_vertex_normal_accumulator_unit #(
    parameter int MAX_VERTICES = mvna_pkg::MAX_VERTICES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  mvna_pkg::t_in              i_in_data,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output mvna_pkg::t_out             o_out_data,
    input  logic                       i_out_stall,
    input  logic                       i_cfg_valid,
    input  logic [mvna_pkg::CFG_W-1:0] i_cfg_data,
    output logic                       o_cfg_ready
);
    import mvna_pkg::*;

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int PSW = 3 * POS_W;
    localparam int SSW = 3 * SUM_W;

    t_state r_state, n_state;
    logic [CFG_W-1:0]         r_cfg;
    t_in                      r_item;
    logic                     r_bad, r_zero;
    logic [2:0]               r_k;
    logic [AW-1:0]            r_clr;
    logic [PSW-1:0]           r_slot [4];
    logic signed [EDGE_W-1:0] r_e1 [3];
    logic signed [EDGE_W-1:0] r_e2 [3];
    t_out                     r_out;
    logic                     r_out_valid;

    logic [31:0]              lim;
    logic                     bad;
    logic [IDX_W-1:0]         corner_idx, pos_idx;
    logic [2:0]               used;
    logic                     pos_we, sum_we;
    logic [AW-1:0]            pos_raddr, sum_waddr, sum_raddr;
    logic [PSW-1:0]           pos_rdata;
    logic [SSW-1:0]           sum_wdata, sum_rdata;
    logic signed [SUM_W-1:0]  sum_v [3];
    t_vec_ctl                 vctl;
    t_vec_sts                 vsts;
    logic signed [UNIT_W-1:0] vu [3];
    t_mode                    mode;

    function automatic logic signed [SUM_W-1:0] sat_add(logic signed [SUM_W-1:0] a,
                                                        logic signed [UNIT_W-1:0] b);
        logic signed [SUM_W:0] t;
        t = (SUM_W+1)'(a) + (SUM_W+1)'(b);
        if (t[SUM_W] != t[SUM_W-1]) begin
            return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return t[SUM_W-1:0];
    endfunction

    function automatic logic [AW-1:0] to_addr(logic [IDX_W-1:0] idx);
        return AW'(32'(idx));
    endfunction

    always_comb begin
        mode = t_mode'(r_item.mode);
        lim  = (32'(r_cfg) > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES) : 32'(r_cfg);
        used = (mode == MODE_QUAD) ? 3'd4 : 3'd3;
        bad  = (32'(r_item.corner_a) >= lim);
        if (mode == MODE_TRI || mode == MODE_QUAD) begin
            bad = bad || (32'(r_item.corner_b) >= lim) || (32'(r_item.corner_c) >= lim);
        end
        if (mode == MODE_QUAD) begin
            bad = bad || (32'(r_item.corner_d) >= lim);
        end
        unique case (r_k[1:0])
            2'd0: corner_idx = r_item.corner_a;
            2'd1: corner_idx = r_item.corner_b;
            2'd2: corner_idx = r_item.corner_c;
            default: corner_idx = r_item.corner_d;
        endcase
        unique case (r_k[1:0])
            2'd0: pos_idx = (mode == MODE_QUAD) ? r_item.corner_d : r_item.corner_b;
            2'd1: pos_idx = (mode == MODE_QUAD) ? r_item.corner_b : r_item.corner_a;
            2'd2: pos_idx = r_item.corner_c;
            default: pos_idx = r_item.corner_a;
        endcase
        for (int j = 0; j < 3; j++) begin
            sum_v[j] = sum_rdata[SSW-1-j*SUM_W -: SUM_W];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == AW'(MAX_VERTICES - 1)) n_state = S_IDLE;
            S_IDLE:   if (i_in_valid) n_state = S_CHECK;
            S_CHECK: begin
                if (bad) begin
                    n_state = S_FINISH;
                end else begin
                    unique case (mode)
                        MODE_LOAD: n_state = S_LOAD;
                        MODE_READ: n_state = S_RDSUM;
                        default:   n_state = S_RDPOS;
                    endcase
                end
            end
            S_LOAD:   n_state = S_FINISH;
            S_RDPOS:  if (r_k == 3'd4) n_state = S_EDGE;
            S_EDGE:   n_state = S_VSTART;
            S_RDSUM:  n_state = S_VSTART;
            S_VSTART: n_state = S_VWAIT;
            S_VWAIT: begin
                if (vsts.done) begin
                    n_state = (mode != MODE_READ && !vsts.zero) ? S_ACC_RD : S_FINISH;
                end
            end
            S_ACC_RD: n_state = S_ACC_WR;
            S_ACC_WR: n_state = (r_k == used - 3'd1) ? S_FINISH : S_ACC_RD;
            S_FINISH: if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = r_state != S_IDLE;
        o_cfg_ready = 1'b1;
        pos_we      = r_state == S_LOAD;
        pos_raddr   = to_addr(pos_idx);
        sum_we      = 1'b0;
        sum_waddr   = to_addr(r_item.corner_a);
        sum_wdata   = '0;
        sum_raddr   = (r_state == S_RDSUM) ? to_addr(r_item.corner_a) : to_addr(corner_idx);
        vctl.start  = r_state == S_VSTART;
        vctl.face   = mode != MODE_READ;
        unique case (r_state)
            S_CLEAR: begin
                sum_we    = 1'b1;
                sum_waddr = r_clr;
            end
            S_LOAD: sum_we = 1'b1;
            S_ACC_WR: begin
                sum_we    = 1'b1;
                sum_waddr = to_addr(corner_idx);
                sum_wdata = {sat_add(sum_v[0], vu[0]), sat_add(sum_v[1], vu[1]),
                             sat_add(sum_v[2], vu[2])};
            end
            default: sum_we = 1'b0;
        endcase
        o_out_valid = r_out_valid;
        o_out_data  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cfg       <= CFG_RESET;
            r_clr       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_cfg <= i_cfg_data;
            if (r_state == S_FINISH && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + AW'(1);
                S_IDLE:  if (i_in_valid) r_item <= i_in_data;
                S_CHECK: begin
                    r_bad  <= bad;
                    r_zero <= 1'b0;
                    r_k    <= '0;
                end
                S_RDPOS: begin
                    r_k <= r_k + 3'd1;
                    if (r_k != 3'd0) r_slot[r_k[1:0] - 2'd1] <= pos_rdata;
                end
                S_EDGE: begin
                    for (int j = 0; j < 3; j++) begin
                        r_e1[j] <= EDGE_W'(signed'(r_slot[0][PSW-1-j*POS_W -: POS_W]))
                                 - EDGE_W'(signed'(r_slot[1][PSW-1-j*POS_W -: POS_W]));
                        r_e2[j] <= EDGE_W'(signed'(r_slot[2][PSW-1-j*POS_W -: POS_W]))
                                 - EDGE_W'(signed'(r_slot[3][PSW-1-j*POS_W -: POS_W]));
                    end
                end
                S_VWAIT: begin
                    r_k <= '0;
                    if (vsts.done) r_zero <= vsts.zero;
                end
                S_ACC_WR: r_k <= r_k + 3'd1;
                S_FINISH: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.bad_index   <= r_bad;
                        r_out.zero_length <= !r_bad && r_zero;
                        if (!r_bad && !r_zero && mode == MODE_READ) begin
                            r_out.normal_x <= NRM_W'(vu[0]);
                            r_out.normal_y <= NRM_W'(vu[1]);
                            r_out.normal_z <= NRM_W'(vu[2]);
                        end else begin
                            r_out.normal_x <= '0;
                            r_out.normal_y <= '0;
                            r_out.normal_z <= '0;
                        end
                    end
                end
                default: r_k <= r_k;
            endcase
        end
    end

    mvna_ram #(.WIDTH(PSW), .DEPTH(MAX_VERTICES)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (to_addr(r_item.corner_a)),
        .i_wdata ({r_item.pos_x, r_item.pos_y, r_item.pos_z}),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    mvna_ram #(.WIDTH(SSW), .DEPTH(MAX_VERTICES)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

    mvna_vec_unit u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (vctl),
        .i_e1    (r_e1),
        .i_e2    (r_e2),
        .i_sum   (sum_v),
        .o_sts   (vsts),
        .o_u     (vu)
    );

`ifndef SYNTHESIS
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> r_state == S_IDLE) else $error("accept while busy");
    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_FINISH) else $error("stray result");
    a_acc_only_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ACC_WR |-> !r_bad && !r_zero) else $error("bad accumulate");
`endif
endmodule
